// ===== rtl/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
// Used by the engine, the top level and the checker; no dependencies.
package bpa_pkg;

  localparam int MAP_BYTES_DEF   = 4096;
  localparam int BLOCK_SHIFT_DEF = 12;

  localparam logic [14:0] START_RESET = 15'd256;
  localparam logic [7:0]  FULL_BYTE   = 8'hFF;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_RESERVE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_PREP,
    S_SUM,
    S_CHECK,
    S_RANGE,
    S_DONE
  } state_t;

  function automatic logic [2:0] lowest_zero(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] m;
    m = 8'd0;
    for (int i = 0; i < 8; i++) begin
      m[i] = (3'(i) >= lo) && (3'(i) <= hi);
    end
    return m;
  endfunction

endpackage

// ===== rtl/bpa_map_ram.sv =====
// Reserved-bit map storage: one synchronous RAM with one write and one read port.
// Read data is registered. Depends on nothing.
module bpa_map_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bpa_engine.sv =====
// Request sequencer for the bitmap page allocator: clearing pass, allocation
// scan, range read-modify-write and the result register. Uses bpa_pkg.
module bpa_engine #(
  parameter int MAP_BYTES   = bpa_pkg::MAP_BYTES_DEF,
  parameter int BLOCK_SHIFT = bpa_pkg::BLOCK_SHIFT_DEF,
  parameter int AW          = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [14:0]   cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_req_type,
  input  logic [31:0]   in_addr,
  input  logic [31:0]   in_end_addr,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   out_block_addr,
  output logic [1:0]    out_status,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata
);

  localparam int              TOTAL     = MAP_BYTES * 8;
  localparam logic [AW-1:0]   LAST_BYTE = AW'(MAP_BYTES - 1);
  localparam logic [32:0]     TOTAL33   = 33'(TOTAL);

  bpa_pkg::state_t  state_r, state_nxt;
  bpa_pkg::req_t    req_r, req_nxt;
  bpa_pkg::status_t res_status_r, res_status_nxt;
  bpa_pkg::status_t out_status_r;

  logic [14:0]   start_r;
  logic [AW-1:0] cur_r, cur_nxt;
  logic          iss_r, iss_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_byte_r, pend_byte_nxt;
  logic [7:0]    cur_mask_r, cur_mask_nxt;
  logic [7:0]    pend_mask_r, pend_mask_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [31:0]   end_r, end_nxt;
  logic [31:0]   diff_r, diff_nxt;
  logic          lt_r, lt_nxt;
  logic [31:0]   first_r, first_nxt;
  logic [32:0]   last_r, last_nxt;
  logic [AW-1:0] fb_r, fb_nxt;
  logic [AW-1:0] lb_r, lb_nxt;
  logic [2:0]    lo_r, lo_nxt;
  logic [2:0]    hi_r, hi_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_addr_r;
  logic          load;

  logic [31:0]   start32;
  logic [7:0]    eff;
  logic          hit;
  logic [2:0]    bitx;
  logic          issue;
  logic          empty;
  logic          skip;
  logic [32:0]   lastc;
  logic [2:0]    rlo, rhi;
  logic [7:0]    rmask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_CLEAR;
      start_r     <= bpa_pkg::START_RESET;
      cur_r       <= '0;
      iss_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    res_status_r <= res_status_nxt;
    pend_byte_r  <= pend_byte_nxt;
    cur_mask_r   <= cur_mask_nxt;
    pend_mask_r  <= pend_mask_nxt;
    addr_r       <= addr_nxt;
    end_r        <= end_nxt;
    diff_r       <= diff_nxt;
    lt_r         <= lt_nxt;
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    fb_r         <= fb_nxt;
    lb_r         <= lb_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    res_addr_r   <= res_addr_nxt;
    if (load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    res_status_nxt = res_status_r;
    cur_nxt        = cur_r;
    iss_nxt        = iss_r;
    pend_nxt       = 1'b0;
    pend_byte_nxt  = cur_r;
    cur_mask_nxt   = cur_mask_r;
    pend_mask_nxt  = cur_mask_r;
    addr_nxt       = addr_r;
    end_nxt        = end_r;
    diff_nxt       = diff_r;
    lt_nxt         = lt_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    fb_nxt         = fb_r;
    lb_nxt         = lb_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    res_addr_nxt   = res_addr_r;
    load           = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = pend_byte_r;
    mem_wdata      = bpa_pkg::FULL_BYTE;
    mem_raddr      = cur_r;

    start32 = 32'(start_r);
    eff     = mem_rdata | pend_mask_r;
    hit     = pend_r && (eff != bpa_pkg::FULL_BYTE);
    bitx    = bpa_pkg::lowest_zero(eff);
    issue   = 1'b0;
    empty   = ((req_r == bpa_pkg::REQ_RELEASE) && !lt_r) || ({1'b0, first_r} > last_r);
    skip    = last_r >= TOTAL33;
    lastc   = skip ? (TOTAL33 - 33'd1) : last_r;
    rlo     = (pend_byte_r == fb_r) ? lo_r : 3'd0;
    rhi     = (pend_byte_r == lb_r) ? hi_r : 3'd7;
    rmask   = bpa_pkg::span_mask(rlo, rhi);

    case (state_r)
      bpa_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = bpa_pkg::FULL_BYTE;
        if (cur_r == LAST_BYTE) begin
          cur_nxt   = '0;
          state_nxt = bpa_pkg::S_IDLE;
        end else begin
          cur_nxt = cur_r + AW'(1);
        end
      end
      bpa_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt   = bpa_pkg::req_t'(in_req_type);
          addr_nxt  = in_addr;
          end_nxt   = in_end_addr;
          state_nxt = (bpa_pkg::req_t'(in_req_type) == bpa_pkg::REQ_ALLOC) ?
                      bpa_pkg::S_ALLOC : bpa_pkg::S_PREP;
        end
      end
      bpa_pkg::S_ALLOC: begin
        res_addr_nxt = '0;
        if (start32 >= 32'(TOTAL)) begin
          res_status_nxt = bpa_pkg::ST_NO_FREE;
          state_nxt      = bpa_pkg::S_DONE;
        end else begin
          cur_nxt      = start32[AW+2:3];
          cur_mask_nxt = ~(bpa_pkg::FULL_BYTE << start_r[2:0]);
          iss_nxt      = 1'b1;
          state_nxt    = bpa_pkg::S_SCAN;
        end
      end
      bpa_pkg::S_SCAN: begin
        issue    = iss_r && !hit;
        pend_nxt = issue;
        if (issue) begin
          cur_mask_nxt = 8'd0;
          if (cur_r == LAST_BYTE) begin
            iss_nxt = 1'b0;
          end else begin
            cur_nxt = cur_r + AW'(1);
          end
        end
        if (hit) begin
          mem_we         = 1'b1;
          mem_waddr      = pend_byte_r;
          mem_wdata      = mem_rdata | (8'd1 << bitx);
          res_addr_nxt   = 32'({pend_byte_r, bitx}) << BLOCK_SHIFT;
          res_status_nxt = bpa_pkg::ST_OK;
          iss_nxt        = 1'b0;
          state_nxt      = bpa_pkg::S_DONE;
        end else if (pend_r && !iss_r) begin
          res_status_nxt = bpa_pkg::ST_NO_FREE;
          state_nxt      = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_PREP: begin
        first_nxt = addr_r >> BLOCK_SHIFT;
        diff_nxt  = end_r - addr_r - 32'd1;
        lt_nxt    = addr_r < end_r;
        state_nxt = bpa_pkg::S_SUM;
      end
      bpa_pkg::S_SUM: begin
        case (req_r)
          bpa_pkg::REQ_RESERVE: last_nxt = {1'b0, end_r >> BLOCK_SHIFT};
          bpa_pkg::REQ_RELEASE: last_nxt = {1'b0, first_r} + {1'b0, diff_r >> BLOCK_SHIFT};
          default:              last_nxt = {1'b0, first_r};
        endcase
        state_nxt = bpa_pkg::S_CHECK;
      end
      bpa_pkg::S_CHECK: begin
        res_addr_nxt = '0;
        if (empty) begin
          res_status_nxt = bpa_pkg::ST_OK;
          state_nxt      = bpa_pkg::S_DONE;
        end else if ({1'b0, first_r} >= TOTAL33) begin
          res_status_nxt = bpa_pkg::ST_OUT_OF_RANGE;
          state_nxt      = bpa_pkg::S_DONE;
        end else begin
          res_status_nxt = skip ? bpa_pkg::ST_OUT_OF_RANGE : bpa_pkg::ST_OK;
          fb_nxt         = first_r[AW+2:3];
          lb_nxt         = lastc[AW+2:3];
          lo_nxt         = first_r[2:0];
          hi_nxt         = lastc[2:0];
          cur_nxt        = first_r[AW+2:3];
          iss_nxt        = 1'b1;
          state_nxt      = bpa_pkg::S_RANGE;
        end
      end
      bpa_pkg::S_RANGE: begin
        issue    = iss_r;
        pend_nxt = issue;
        if (issue) begin
          if (cur_r == lb_r) begin
            iss_nxt = 1'b0;
          end else begin
            cur_nxt = cur_r + AW'(1);
          end
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_byte_r;
          mem_wdata = (req_r == bpa_pkg::REQ_RESERVE) ? (mem_rdata | rmask) :
                                                        (mem_rdata & ~rmask);
          if (!iss_r) begin
            state_nxt = bpa_pkg::S_DONE;
          end
        end
      end
      bpa_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bpa_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && out_stall) || load;
  end

  assign in_stall       = (state_r != bpa_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_block_addr = out_addr_r;
  assign out_status     = out_status_r;

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
// Top level of the bitmap page allocator: the engine and the map RAM.
// Depends on bpa_pkg, bpa_engine and bpa_map_ram.
//
// After reset the block writes every map byte to all reserved and holds
// in_stall high meanwhile; configuration writes are taken throughout. The map
// is one byte-wide RAM with one read and one write port, and one request is
// worked at a time. An allocate scans the map bytes from the start block up to
// the byte holding the first free block. Free, release-range and reserve-range
// walk the map bytes touched; the byte walk reads one byte and writes back the
// previous one each cycle. A finished result sits in an output register, so
// the next transaction is taken while it waits.
module bitmap_page_allocator #(
  parameter int MAP_BYTES   = bpa_pkg::MAP_BYTES_DEF,
  parameter int BLOCK_SHIFT = bpa_pkg::BLOCK_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_addr,
  input  logic [31:0] in_end_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_block_addr,
  output logic [1:0]  out_status
);

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  bpa_engine #(
    .MAP_BYTES   (MAP_BYTES),
    .BLOCK_SHIFT (BLOCK_SHIFT),
    .AW          (AW)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_addr        (in_addr),
    .in_end_addr    (in_end_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_block_addr (out_block_addr),
    .out_status     (out_status),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  bpa_map_ram #(
    .DEPTH (MAP_BYTES),
    .AW    (AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/bpa_checker.sv =====
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator.
module bpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [14:0] cfg_wdata,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_req_type,
  input logic [31:0] in_addr,
  input logic [31:0] in_end_addr,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_block_addr,
  input logic [1:0]  out_status
);

  // The clearing pass keeps the input side stalled right after reset.
  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // One transaction is worked at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_block_addr) && $stable(out_status)))
    else $error("stalled result changed");

  // Only a successful allocation carries an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bpa_pkg::ST_OK) |-> (out_block_addr == 32'd0))
    else $error("nonzero address with failure status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("undefined status code");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
